FILE: rtl/tapl_pkg.sv
// ----------------------------------------------------------------------------
// tapl_pkg: shared types and constants of the taper axis plane transform
// Widths, configuration register codes and the structs that pass between
// the lanes, the merge stage and the top level.
// ----------------------------------------------------------------------------
package tapl_pkg;

  localparam int CoordW   = 32;             // coordinate width
  localparam int GeoW     = 20;             // geometry register width
  localparam int MulW     = GeoW + 1;       // multiplier factor, holds H+D
  localparam int ProdW    = CoordW + MulW;  // product and quotient width
  localparam int SumW     = ProdW + 2;      // width of the final sums
  localparam int LimW     = 32;             // clamp limit width
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int LaneDepth = ProdW + 2;     // input reg, product reg, divider

  localparam logic FuncFwd = 1'b0;
  localparam logic FuncInv = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPlane = 3'd0,
    CfgLower = 3'd1,
    CfgThick = 3'd2,
    CfgUHi   = 3'd3,
    CfgULo   = 3'd4,
    CfgVHi   = 3'd5,
    CfgVLo   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic                     func;
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
  } req_t;

  typedef struct packed {
    logic signed [CoordW-1:0] p_x;
    logic signed [CoordW-1:0] p_y;
    logic signed [CoordW-1:0] q_x;
    logic signed [CoordW-1:0] q_y;
    logic                     geom_valid;
  } rsp_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] value;
  } cfg_t;

  typedef struct packed {
    logic [CoordW-1:0]        mag;
    logic                     neg;
    logic signed [CoordW-1:0] base;
    logic [MulW-1:0]          m1;
    logic [MulW-1:0]          m2;
    logic [GeoW-1:0]          dvs;
  } lane_in_t;

  typedef struct packed {
    logic [ProdW-1:0]         q1;
    logic [ProdW-1:0]         q2;
    logic                     neg;
    logic signed [CoordW-1:0] base;
  } lane_out_t;

  typedef struct packed {
    logic signed [LimW-1:0] u_hi;
    logic signed [LimW-1:0] u_lo;
    logic signed [LimW-1:0] v_hi;
    logic signed [LimW-1:0] v_lo;
  } lim_t;

  typedef struct packed {
    logic vld;
    logic inv;
    logic geom;
  } ctl_t;

endpackage

FILE: rtl/tapl_if.sv
// ----------------------------------------------------------------------------
// tapl_if: request, response and configuration channels
// Valid/ready channels carrying the payload structs of tapl_pkg.
// ----------------------------------------------------------------------------
interface tapl_req_if;
  logic          valid;
  logic          ready;
  tapl_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tapl_rsp_if;
  logic          valid;
  logic          ready;
  tapl_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tapl_cfg_if;
  logic          valid;
  logic          ready;
  tapl_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/tapl_lane.sv
// ----------------------------------------------------------------------------
// tapl_lane: one axis lane
// Forms two products of a magnitude and divides both by a shared divisor in
// a restoring divider pipeline that resolves one quotient bit per stage.
// ----------------------------------------------------------------------------
module tapl_lane (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  tapl_pkg::lane_in_t   lane_i,
  output tapl_pkg::lane_out_t  lane_o
);

  typedef struct packed {
    logic [tapl_pkg::ProdW-1:0]         dv1;
    logic [tapl_pkg::ProdW-1:0]         dv2;
    logic [tapl_pkg::GeoW-1:0]          r1;
    logic [tapl_pkg::GeoW-1:0]          r2;
    logic [tapl_pkg::GeoW-1:0]          dvs;
    logic                               neg;
    logic signed [tapl_pkg::CoordW-1:0] base;
  } dst_t;

  tapl_pkg::lane_in_t in_q;
  dst_t st_q [tapl_pkg::ProdW+1];
  dst_t st_d [tapl_pkg::ProdW+1];

  logic [tapl_pkg::GeoW:0] t1 [tapl_pkg::ProdW];
  logic [tapl_pkg::GeoW:0] t2 [tapl_pkg::ProdW];
  logic [tapl_pkg::GeoW:0] n1 [tapl_pkg::ProdW];
  logic [tapl_pkg::GeoW:0] n2 [tapl_pkg::ProdW];
  logic                    ge1 [tapl_pkg::ProdW];
  logic                    ge2 [tapl_pkg::ProdW];

  always_comb begin
    st_d[0].dv1  = tapl_pkg::ProdW'(in_q.mag) * tapl_pkg::ProdW'(in_q.m1);
    st_d[0].dv2  = tapl_pkg::ProdW'(in_q.mag) * tapl_pkg::ProdW'(in_q.m2);
    st_d[0].r1   = '0;
    st_d[0].r2   = '0;
    st_d[0].dvs  = in_q.dvs;
    st_d[0].neg  = in_q.neg;
    st_d[0].base = in_q.base;
    // The partial remainder stays below the divisor, so one compare and
    // subtract per stage is enough.
    for (int k = 0; k < tapl_pkg::ProdW; k++) begin
      t1[k]  = {st_q[k].r1, st_q[k].dv1[tapl_pkg::ProdW-1]};
      t2[k]  = {st_q[k].r2, st_q[k].dv2[tapl_pkg::ProdW-1]};
      ge1[k] = t1[k] >= {1'b0, st_q[k].dvs};
      ge2[k] = t2[k] >= {1'b0, st_q[k].dvs};
      n1[k]  = ge1[k] ? (t1[k] - {1'b0, st_q[k].dvs}) : t1[k];
      n2[k]  = ge2[k] ? (t2[k] - {1'b0, st_q[k].dvs}) : t2[k];
      st_d[k+1].r1   = n1[k][tapl_pkg::GeoW-1:0];
      st_d[k+1].r2   = n2[k][tapl_pkg::GeoW-1:0];
      st_d[k+1].dv1  = {st_q[k].dv1[tapl_pkg::ProdW-2:0], ge1[k]};
      st_d[k+1].dv2  = {st_q[k].dv2[tapl_pkg::ProdW-2:0], ge2[k]};
      st_d[k+1].dvs  = st_q[k].dvs;
      st_d[k+1].neg  = st_q[k].neg;
      st_d[k+1].base = st_q[k].base;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      in_q <= lane_i;
      st_q <= st_d;
    end
  end

  assign lane_o.q1   = st_q[tapl_pkg::ProdW].dv1;
  assign lane_o.q2   = st_q[tapl_pkg::ProdW].dv2;
  assign lane_o.neg  = st_q[tapl_pkg::ProdW].neg;
  assign lane_o.base = st_q[tapl_pkg::ProdW].base;

endmodule

FILE: rtl/tapl_merge.sv
// ----------------------------------------------------------------------------
// tapl_merge: combine lane quotients into one response
// Applies signs, forms the forward or inverse sums, clamps the upper motor
// offsets to the limits in forward mode and saturates every coordinate.
// ----------------------------------------------------------------------------
module tapl_merge (
  input  tapl_pkg::lane_out_t lx_i,
  input  tapl_pkg::lane_out_t ly_i,
  input  tapl_pkg::ctl_t      ctl_i,
  input  tapl_pkg::lim_t      lim_i,
  output tapl_pkg::rsp_t      rsp_o
);

  localparam int SumW  = tapl_pkg::SumW;
  localparam int CoordW = tapl_pkg::CoordW;
  localparam logic signed [SumW-1:0] SatMax =
    {{(SumW-CoordW+1){1'b0}}, {(CoordW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SatMin = ~SatMax;

  function automatic logic signed [SumW-1:0] signed_q(
    input logic [tapl_pkg::ProdW-1:0] m, input logic n);
    logic signed [SumW-1:0] v;
    v = {2'b00, m};
    return n ? -v : v;
  endfunction

  function automatic logic signed [SumW-1:0] ext_lim(
    input logic signed [tapl_pkg::LimW-1:0] l);
    return {{(SumW-tapl_pkg::LimW){l[tapl_pkg::LimW-1]}}, l};
  endfunction

  function automatic logic signed [CoordW-1:0] sat(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] r;
    r = v;
    if (v > SatMax) r = SatMax;
    if (v < SatMin) r = SatMin;
    return r[CoordW-1:0];
  endfunction

  function automatic logic signed [SumW-1:0] clamp(input logic signed [SumW-1:0] v,
    input logic signed [SumW-1:0] hi, input logic signed [SumW-1:0] lo);
    logic signed [SumW-1:0] r;
    r = v;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r;
  endfunction

  logic signed [SumW-1:0] bx, by, sx1, sx2, sy1, sy2, px, py, qx, qy;

  always_comb begin
    bx  = {{(SumW-CoordW){lx_i.base[CoordW-1]}}, lx_i.base};
    by  = {{(SumW-CoordW){ly_i.base[CoordW-1]}}, ly_i.base};
    sx1 = signed_q(lx_i.q1, lx_i.neg);
    sx2 = signed_q(lx_i.q2, lx_i.neg);
    sy1 = signed_q(ly_i.q1, ly_i.neg);
    sy2 = signed_q(ly_i.q2, ly_i.neg);
    if (ctl_i.inv == tapl_pkg::FuncInv) begin
      px = bx + sx1;
      py = by + sy1;
      qx = bx + sx2;
      qy = by + sy2;
    end else begin
      px = bx - sx1;
      py = by - sy1;
      qx = clamp(sx2, ext_lim(lim_i.u_hi), ext_lim(lim_i.u_lo));
      qy = clamp(sy2, ext_lim(lim_i.v_hi), ext_lim(lim_i.v_lo));
    end
    rsp_o.p_x        = sat(px);
    rsp_o.p_y        = sat(py);
    rsp_o.q_x        = sat(qx);
    rsp_o.q_y        = sat(qy);
    rsp_o.geom_valid = ctl_i.geom;
  end

endmodule

FILE: rtl/taper_axis_plane_transform.sv
// ----------------------------------------------------------------------------
// taper_axis_plane_transform: two-plane coordinate transform
// Forward and inverse mapping between workpiece and motor coordinates of a
// four-axis taper cutter, with one lane for X, one lane for Y and a merge stage.
// ----------------------------------------------------------------------------
// Pipeline: the input register, the product register and the divider
//   pipeline, which resolves one quotient bit per stage in each lane, feed
//   the merge stage and the output register.
// Throughput: one request per cycle; the pipeline stalls only while its last
//   stage and the output register both hold a response that is not taken.
// Reset: geometry registers clear to zero, limits go to the full 32-bit
//   range, and the pipeline and output register empty.
module taper_axis_plane_transform (
  input  logic         clk_i,
  input  logic         rst_ni,
  tapl_req_if.sink     req_i,
  tapl_rsp_if.source   rsp_o,
  tapl_cfg_if.sink     cfg_i
);

  localparam int CoordW = tapl_pkg::CoordW;
  localparam int GeoW   = tapl_pkg::GeoW;
  localparam int Last   = tapl_pkg::LaneDepth - 1;

  logic [GeoW-1:0] plane_q, lower_q, thick_q;
  tapl_pkg::lim_t  lim_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q    <= '0;
      lower_q    <= '0;
      thick_q    <= '0;
      lim_q.u_hi <= 32'sh7fff_ffff;
      lim_q.u_lo <= 32'sh8000_0000;
      lim_q.v_hi <= 32'sh7fff_ffff;
      lim_q.v_lo <= 32'sh8000_0000;
    end else if (cfg_i.valid) begin
      unique case (tapl_pkg::cfg_idx_e'(cfg_i.data.index))
        tapl_pkg::CfgPlane: plane_q    <= cfg_i.data.value[GeoW-1:0];
        tapl_pkg::CfgLower: lower_q    <= cfg_i.data.value[GeoW-1:0];
        tapl_pkg::CfgThick: thick_q    <= cfg_i.data.value[GeoW-1:0];
        tapl_pkg::CfgUHi:   lim_q.u_hi <= cfg_i.data.value;
        tapl_pkg::CfgULo:   lim_q.u_lo <= cfg_i.data.value;
        tapl_pkg::CfgVHi:   lim_q.v_hi <= cfg_i.data.value;
        tapl_pkg::CfgVLo:   lim_q.v_lo <= cfg_i.data.value;
        default: ;
      endcase
    end
  end

  logic [tapl_pkg::MulW-1:0] hd_sum;
  logic geom_ok, inv;

  assign hd_sum  = {1'b0, lower_q} + {1'b0, thick_q};
  assign geom_ok = (plane_q != '0) && (lower_q != '0) && (thick_q != '0) &&
                   (hd_sum < {1'b0, plane_q});
  assign inv     = req_i.data.func == tapl_pkg::FuncInv;

  function automatic tapl_pkg::lane_in_t prep(
    input logic signed [CoordW-1:0] a, input logic signed [CoordW-1:0] b,
    input logic inv_m, input logic ok, input logic [GeoW-1:0] l,
    input logic [GeoW-1:0] h, input logic [GeoW-1:0] d,
    input logic [tapl_pkg::MulW-1:0] hd);
    tapl_pkg::lane_in_t r;
    logic [CoordW:0] dx, ab;
    // Forward scales the slope U-X, inverse scales the offset itself.
    dx = inv_m ? {b[CoordW-1], b} : ({b[CoordW-1], b} - {a[CoordW-1], a});
    ab = dx[CoordW] ? (~dx + 1'b1) : dx;
    r.mag  = ab[CoordW-1:0];
    r.neg  = dx[CoordW];
    r.base = a;
    // Invalid geometry zeroes both products, so P passes the A inputs through.
    r.m1   = ok ? {1'b0, h} : '0;
    r.m2   = ok ? (inv_m ? hd : {1'b0, l}) : '0;
    r.dvs  = ok ? (inv_m ? l : d) : GeoW'(1);
    return r;
  endfunction

  tapl_pkg::lane_in_t  lx_in, ly_in;
  tapl_pkg::lane_out_t lx_out, ly_out;
  tapl_pkg::ctl_t      ctl_q [tapl_pkg::LaneDepth];
  tapl_pkg::rsp_t      mrg, odata_q;
  logic                ovld_q, adv, accept;

  assign lx_in  = prep(req_i.data.a_x, req_i.data.b_x, inv, geom_ok,
                       plane_q, lower_q, thick_q, hd_sum);
  assign ly_in  = prep(req_i.data.a_y, req_i.data.b_y, inv, geom_ok,
                       plane_q, lower_q, thick_q, hd_sum);

  assign adv         = !ctl_q[Last].vld || !ovld_q || rsp_o.ready;
  assign req_i.ready = adv;
  assign accept      = req_i.valid && adv;

  tapl_lane u_lane_x (
    .clk_i  (clk_i),
    .en_i   (adv),
    .lane_i (lx_in),
    .lane_o (lx_out)
  );

  tapl_lane u_lane_y (
    .clk_i  (clk_i),
    .en_i   (adv),
    .lane_i (ly_in),
    .lane_o (ly_out)
  );

  tapl_merge u_merge (
    .lx_i  (lx_out),
    .ly_i  (ly_out),
    .ctl_i (ctl_q[Last]),
    .lim_i (lim_q),
    .rsp_o (mrg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tapl_pkg::LaneDepth; i++) ctl_q[i] <= '0;
      ovld_q <= 1'b0;
    end else if (adv) begin
      ctl_q[0].vld  <= req_i.valid;
      ctl_q[0].inv  <= inv;
      ctl_q[0].geom <= geom_ok;
      for (int i = 1; i < tapl_pkg::LaneDepth; i++) ctl_q[i] <= ctl_q[i-1];
      ovld_q <= ctl_q[Last].vld || (ovld_q && !rsp_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && ctl_q[Last].vld) begin
      odata_q <= mrg;
    end
  end

  assign rsp_o.valid = ovld_q;
  assign rsp_o.data  = odata_q;

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ctl_q[0].vld)
    else $error("accepted request did not enter the pipeline");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q[Last].vld && !adv) |=> ctl_q[Last].vld)
    else $error("stalled last stage lost its request");

  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovld_q) |-> $past(ctl_q[Last].vld))
    else $error("response appeared without a finished request");

endmodule

FILE: dv/taper_axis_plane_transform_tb.sv
// ----------------------------------------------------------------------------
// taper_axis_plane_transform_tb: self-checking testbench of the plane transform
// A queue-fed driver sends forward and inverse requests under several
// geometry and limit settings. A monitor compares every response, field by
// field, with the value that a local model of the transform predicts.
// ----------------------------------------------------------------------------
module taper_axis_plane_transform_tb;

  localparam int CoordW = tapl_pkg::CoordW;
  localparam int GeoW   = tapl_pkg::GeoW;
  localparam int LatencyCycles = CoordW + 24;
  localparam longint CoordMax = (64'sd1 <<< (CoordW - 1)) - 1;
  localparam longint CoordMin = -CoordMax - 1;
  localparam longint unsigned CapMag = 64'd1 << 52;

  logic clk_i = 1'b0;
  logic rst_ni;

  tapl_req_if req_if ();
  tapl_rsp_if rsp_if ();
  tapl_cfg_if cfg_if ();

  taper_axis_plane_transform i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // Local copy of the configuration registers.
  longint unsigned geo_l, geo_h, geo_d;
  longint lim_uh, lim_ul, lim_vh, lim_vl;

  tapl_pkg::req_t pending_reqs[$];
  tapl_pkg::rsp_t expected_rsps[$];
  int   send_idle_pct, recv_idle_pct;
  bit   hold_reqs;
  int   mismatch_count;

  function automatic longint scale_trunc(longint a, longint unsigned m, longint unsigned d);
    longint unsigned mag, q, r, res;
    mag = (a < 0) ? longint'(0) - a : a;
    q   = mag / d;
    r   = mag % d;
    if (m != 0 && q > CapMag / m) res = CapMag;
    else begin
      res = q * m + (r * m) / d;
      if (res > CapMag) res = CapMag;
    end
    return (a < 0) ? -longint'(res) : longint'(res);
  endfunction

  function automatic logic signed [CoordW-1:0] sat_coord(longint v);
    if (v > CoordMax) return CoordMax[CoordW-1:0];
    if (v < CoordMin) return CoordMin[CoordW-1:0];
    return v[CoordW-1:0];
  endfunction

  function automatic longint clamp_lim(longint v, longint hi, longint lo);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  function automatic tapl_pkg::rsp_t predict_transform(tapl_pkg::req_t r);
    tapl_pkg::rsp_t o;
    bit     ok;
    longint ax, ay, bx, by, px, py, qx, qy;
    ok = geo_l > 0 && geo_h > 0 && geo_d > 0 && geo_h + geo_d < geo_l;
    ax = r.a_x; ay = r.a_y; bx = r.b_x; by = r.b_y;
    if (r.func == tapl_pkg::FuncFwd) begin
      if (ok) begin
        px = ax - scale_trunc(bx - ax, geo_h, geo_d);
        py = ay - scale_trunc(by - ay, geo_h, geo_d);
        qx = scale_trunc(bx - ax, geo_l, geo_d);
        qy = scale_trunc(by - ay, geo_l, geo_d);
      end else begin
        px = ax; py = ay; qx = 0; qy = 0;
      end
      // High clamp first, so a crossed low limit wins.
      qx = clamp_lim(qx, lim_uh, lim_ul);
      qy = clamp_lim(qy, lim_vh, lim_vl);
    end else begin
      if (ok) begin
        px = ax + scale_trunc(bx, geo_h, geo_l);
        py = ay + scale_trunc(by, geo_h, geo_l);
        qx = ax + scale_trunc(bx, geo_h + geo_d, geo_l);
        qy = ay + scale_trunc(by, geo_h + geo_d, geo_l);
      end else begin
        px = ax; py = ay; qx = ax; qy = ay;
      end
    end
    o.p_x = sat_coord(px);
    o.p_y = sat_coord(py);
    o.q_x = sat_coord(qx);
    o.q_y = sat_coord(qy);
    o.geom_valid = ok;
    return o;
  endfunction

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
    end else begin
      if (req_if.valid && req_if.ready) expected_rsps.push_back(predict_transform(req_if.data));
      if (!req_if.valid || req_if.ready) begin
        if (!hold_reqs && pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req_if.data  <= pending_reqs.pop_front();
          req_if.valid <= 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsps.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected response %p", rsp_if.data);
        end else begin
          tapl_pkg::rsp_t exp_rsp;
          exp_rsp = expected_rsps.pop_front();
          if (exp_rsp.p_x !== rsp_if.data.p_x || exp_rsp.p_y !== rsp_if.data.p_y ||
              exp_rsp.q_x !== rsp_if.data.q_x || exp_rsp.q_y !== rsp_if.data.q_y ||
              exp_rsp.geom_valid !== rsp_if.data.geom_valid) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected %p actual %p", exp_rsp, rsp_if.data);
          end
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("taper_axis_plane_transform verification failed");
    $finish;
  end

  // Checked at the falling edge, where every register update has settled.
  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_if.valid || expected_rsps.size() > 0)
      @(negedge clk_i);
    repeat (LatencyCycles + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(tapl_pkg::cfg_idx_e idx, logic [tapl_pkg::CfgDataW-1:0] value);
    cfg_if.data  <= '{index: idx, value: value};
    cfg_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      tapl_pkg::CfgPlane: geo_l = value[GeoW-1:0];
      tapl_pkg::CfgLower: geo_h = value[GeoW-1:0];
      tapl_pkg::CfgThick: geo_d = value[GeoW-1:0];
      tapl_pkg::CfgUHi:   lim_uh = longint'(signed'(value));
      tapl_pkg::CfgULo:   lim_ul = longint'(signed'(value));
      tapl_pkg::CfgVHi:   lim_vh = longint'(signed'(value));
      tapl_pkg::CfgVLo:   lim_vl = longint'(signed'(value));
      default: ;
    endcase
  endtask

  // Geometry writes carry random upper bits, which the block must drop.
  task automatic set_geometry(int unsigned l, int unsigned h, int unsigned d,
                              int uh, int ul, int vh, int vl);
    write_reg(tapl_pkg::CfgPlane, {12'($urandom_range(4095)), l[GeoW-1:0]});
    write_reg(tapl_pkg::CfgLower, {12'($urandom_range(4095)), h[GeoW-1:0]});
    write_reg(tapl_pkg::CfgThick, {12'($urandom_range(4095)), d[GeoW-1:0]});
    write_reg(tapl_pkg::CfgUHi, uh);
    write_reg(tapl_pkg::CfgULo, ul);
    write_reg(tapl_pkg::CfgVHi, vh);
    write_reg(tapl_pkg::CfgVLo, vl);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic add_req(logic f, int ax, int ay, int bx, int by);
    tapl_pkg::req_t r;
    r.func = f; r.a_x = ax; r.a_y = ay; r.b_x = bx; r.b_y = by;
    pending_reqs.push_back(r);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(5))
      0, 1: return $urandom();
      2:    return $signed($urandom_range(200000)) - 100000;
      3:    return $signed($urandom_range(20)) - 10;
      4:    return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(3)
                                     : 32'sh80000000 + $urandom_range(3);
      default: return $signed($urandom_range(4000000)) - 2000000;
    endcase
  endfunction

  task automatic add_random(int n);
    for (int i = 0; i < n; i++)
      add_req(1'($urandom_range(1)), rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  initial begin
    int imax, imin;
    imax = 32'sh7fffffff;
    imin = 32'sh80000000;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    hold_reqs = 1'b0;
    mismatch_count = 0;
    send_idle_pct = 18;
    recv_idle_pct = 75;
    geo_l = 0; geo_h = 0; geo_d = 0;
    lim_uh = imax; lim_ul = imin; lim_vh = imax; lim_vl = imin;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry is invalid, so the P outputs pass the A inputs through.
    add_req(tapl_pkg::FuncFwd, 123, -456, 789, -1011);
    add_req(tapl_pkg::FuncInv, imax, imin, 5, -5);
    add_req(tapl_pkg::FuncFwd, imin, imax, imax, imin);
    wait_drained();

    set_geometry(100000, 20000, 30000, 50000, -40000, 60000, -70000);
    add_req(tapl_pkg::FuncFwd, 0, 0, 0, 0);
    add_req(tapl_pkg::FuncFwd, 1000, 2000, 1300, 1700);
    add_req(tapl_pkg::FuncFwd, -1000, 5, 3, -7);
    add_req(tapl_pkg::FuncFwd, imax, imin, imin, imax);
    add_req(tapl_pkg::FuncFwd, imin, imax, imax, imin);
    add_req(tapl_pkg::FuncFwd, 10, 10, 11, 9);
    add_req(tapl_pkg::FuncInv, 0, 0, 0, 0);
    add_req(tapl_pkg::FuncInv, 500, -500, 7, -7);
    add_req(tapl_pkg::FuncInv, imax, imin, imax, imin);
    add_req(tapl_pkg::FuncInv, imin, imax, imin, imax);
    add_req(tapl_pkg::FuncInv, -3, 3, 99999, -99999);
    add_req(tapl_pkg::FuncInv, imax, imax, imax, imax);
    add_random(400);
    wait_drained();

    // The largest ratio L/D drives the forward offsets past the limits;
    // crossed limits let the low limit win.
    set_geometry(1048575, 1, 1, -100, 100, imax, imin);
    add_random(160);
    while (pending_reqs.size() > 80) @(negedge clk_i);
    hold_reqs = 1'b1;
    while (req_if.valid || expected_rsps.size() > 0) @(negedge clk_i);
    hold_reqs = 1'b0;
    add_random(160);
    wait_drained();

    send_idle_pct = 75;
    recv_idle_pct = 18;
    set_geometry(1048575, 524287, 524287, imin, imax, imin, imax);
    add_random(320);
    wait_drained();

    // H+D equal to L is the invalid edge of the geometry.
    set_geometry(3000, 1000, 2000, 1000, -1000, 0, 0);
    add_random(150);
    wait_drained();
    set_geometry(3, 1, 1, imax, imin, imax, imin);
    add_random(170);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_geometry(0, 5, 5, imax, imin, imax, imin);
    add_random(80);
    wait_drained();
    set_geometry(500000, 0, 1000, imax, imin, imax, imin);
    add_random(80);
    wait_drained();
    set_geometry(200000, 12345, 54321, $urandom(), $urandom(), $urandom(), $urandom());
    add_random(415);
    wait_drained();

    if (mismatch_count == 0 && expected_rsps.size() == 0) begin
      $display("taper_axis_plane_transform verification clean");
    end else begin
      $display("taper_axis_plane_transform verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/tapl_pkg.sv
rtl/tapl_if.sv
rtl/tapl_lane.sv
rtl/tapl_merge.sv
rtl/taper_axis_plane_transform.sv
dv/taper_axis_plane_transform_tb.sv
